@@ sv/ecr_pkg.sv @@
// ecr_pkg: shared payload types, register indexes, status codes and constants
// for the efuse calibration ratio block. No dependencies.
`timescale 1ns / 1ps
package ecr_pkg;
	typedef struct packed {
		logic [15:0] debug_control;
		logic [15:0] current_high_word;
		logic [15:0] current_low_word;
		logic [15:0] voltage_high_word;
		logic [15:0] voltage_low_word;
	} in_t;

	typedef struct packed {
		logic signed [31:0] correction;
		logic [1:0]         status;
	} out_t;

	typedef enum logic [1:0] {
		REG_FIELD_MASK  = 2'd0,
		REG_GAIN_WEIGHT = 2'd1,
		REG_RATIO_SCALE = 2'd2
	} reg_idx_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_DZERO = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam int GAIN_BASE    = 10000;
	localparam int MERGE_OR_BIT = 3;
	localparam int QBITS        = 33;

	localparam logic [15:0] RST_FIELD_MASK  = 16'h03FF;
	localparam logic [9:0]  RST_GAIN_WEIGHT = 10'd1;
	localparam logic [15:0] RST_RATIO_SCALE = 16'd8192;

	localparam logic signed [31:0] CORR_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CORR_MIN = 32'sh8000_0000;
endpackage

@@ sv/ecr_front.sv @@
// ecr_front: accepts items, extracts and merges the calibration fields and
// forms both gains for the queue. Depends on ecr_pkg.
`timescale 1ns / 1ps
module ecr_front import ecr_pkg::*; #(
	parameter int FW = 16,
	parameter int GW = 28
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_t                 in_data,
	input  logic [15:0]         field_mask,
	input  logic [9:0]          gain_weight,
	input  logic                q_full,
	output logic                push,
	output logic [2*GW:0]       push_data
);
	localparam int SHW = $clog2(FW);
	localparam int PW  = FW + 11;

	logic [FW-1:0]  m, low, run, fm, topb;
	logic [FW:0]    msum;
	logic [SHW-1:0] sh;
	logic           use_or;
	logic [FW+15:0] mext;
	logic signed [FW-1:0] ik, vk;
	logic signed [FW-1:0] ik_s1, vk_s1;
	logic           empty_s1, valid_s1;
	logic signed [PW-1:0] iprod, vprod;
	logic signed [GW-1:0]  igain, vgain;

	function automatic logic [FW-1:0] fit(input logic [15:0] w);
		logic [FW+15:0] t;
		t = {{FW{1'b0}}, w};
		return t[FW-1:0];
	endfunction

	function automatic logic [FW-1:0] merge(input logic [15:0] hi, input logic [15:0] lo,
			input logic o, input logic [FW-1:0] r, input logic [SHW-1:0] s,
			input logic [FW-1:0] f, input logic [FW-1:0] tb);
		logic [FW-1:0] a, b, v;
		a = (fit(hi) & r) >> s;
		b = (fit(lo) & r) >> s;
		v = o ? (a | b) : (a & b);
		return (|(v & tb)) ? (v | ~f) : v;
	endfunction

	always_comb begin
		mext = {{FW{1'b0}}, field_mask};
		m    = mext[FW-1:0];
		low  = m & (~m + {{(FW-1){1'b0}}, 1'b1});
		// adding the lowest set bit clears the lowest run of ones
		msum = {1'b0, m} + {1'b0, low};
		run  = m & ~msum[FW-1:0];
		sh   = '0;
		for (int i = 0; i < FW; i++) begin
			if (low[i]) sh = SHW'(i);
		end
		fm     = run >> sh;
		topb   = fm ^ (fm >> 1);
		use_or = in_data.debug_control[MERGE_OR_BIT];
		ik = merge(in_data.current_high_word, in_data.current_low_word, use_or, run, sh, fm, topb);
		vk = merge(in_data.voltage_high_word, in_data.voltage_low_word, use_or, run, sh, fm, topb);
	end

	assign in_stall = valid_s1 & q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ik_s1    <= ik;
			vk_s1    <= vk;
			empty_s1 <= (m == '0);
		end
	end

	always_comb begin
		iprod = PW'($signed({1'b0, gain_weight})) * PW'(ik_s1);
		vprod = PW'($signed({1'b0, gain_weight})) * PW'(vk_s1);
		igain = GW'(iprod) + GW'(GAIN_BASE);
		vgain = GW'(vprod) + GW'(GAIN_BASE);
	end

	assign push      = valid_s1 & ~q_full;
	assign push_data = {empty_s1, igain, vgain};
endmodule

@@ sv/ecr_queue.sv @@
// ecr_queue: four-entry queue between the front and back parts.
// No dependencies beyond ecr_pkg import for house style.
`timescale 1ns / 1ps
module ecr_queue import ecr_pkg::*; #(
	parameter int DW = 57
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output logic [DW-1:0] pop_data
);
	logic [DW-1:0] mem_q [0:3];
	logic [1:0]    wp_q, rp_q;
	logic [2:0]    cnt_q;

	assign full      = (cnt_q == 3'd4);
	assign not_empty = (cnt_q != 3'd0);
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule

@@ sv/ecr_back.sv @@
// ecr_back: scales the current gain, divides by the voltage gain in a
// one-bit-per-stage restoring pipeline and saturates. Depends on ecr_pkg.
`timescale 1ns / 1ps
module ecr_back import ecr_pkg::*; #(
	parameter int GW = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  logic [2*GW:0] q_data,
	output logic          pop,
	input  logic [15:0]   ratio_scale,
	output logic          out_valid,
	input  logic          out_stall,
	output out_t          out_data
);
	localparam int NW = GW + 17;
	localparam int RW = GW + QBITS + 1;

	logic en;
	logic valid_s1, valid_s2;
	logic signed [NW-1:0] n_s1;
	logic signed [GW-1:0] d_s1;
	logic empty_s1, dz_s1;
	logic [NW-1:0] nmag_s2;
	logic [GW-1:0] dmag_s2;
	logic neg_s2, empty_s2, dz_s2;

	logic          vd_q   [0:QBITS];
	logic [RW-1:0] rem_q  [0:QBITS];
	logic [GW-1:0] dv_q   [0:QBITS];
	logic [QBITS-1:0] qt_q [0:QBITS];
	logic          neg_q  [0:QBITS];
	logic          emp_q  [0:QBITS];
	logic          dz_q   [0:QBITS];
	logic          ovf_q  [0:QBITS];

	logic          out_valid_q;
	out_t          out_q;
	logic signed [GW-1:0] qg, qv;
	logic          qe;
	logic [QBITS-1:0] qm, qneg;
	logic          pos_sat, neg_sat;

	// whole back pipe holds while a result waits
	assign en  = ~out_valid_q | ~out_stall;
	assign pop = q_not_empty & en;
	assign {qe, qg, qv} = q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= QBITS; k++) vd_q[k] <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_not_empty;
			valid_s2 <= valid_s1;
			vd_q[0]  <= valid_s2;
			for (int k = 1; k <= QBITS; k++) vd_q[k] <= vd_q[k-1];
			out_valid_q <= vd_q[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1     <= NW'($signed({1'b0, ratio_scale})) * NW'(qg);
			d_s1     <= qv;
			empty_s1 <= qe;
			dz_s1    <= (qv == '0);

			nmag_s2  <= n_s1[NW-1] ? NW'(-n_s1) : NW'(n_s1);
			dmag_s2  <= d_s1[GW-1] ? GW'(-d_s1) : GW'(d_s1);
			neg_s2   <= n_s1[NW-1] ^ d_s1[GW-1];
			empty_s2 <= empty_s1;
			dz_s2    <= dz_s1;

			// quotient magnitude of 2^33 or more always saturates
			rem_q[0] <= RW'(nmag_s2);
			dv_q[0]  <= dmag_s2;
			qt_q[0]  <= '0;
			neg_q[0] <= neg_s2;
			emp_q[0] <= empty_s2;
			dz_q[0]  <= dz_s2;
			ovf_q[0] <= (RW'(nmag_s2) >= (RW'(dmag_s2) << QBITS));

			for (int k = 1; k <= QBITS; k++) begin
				if (rem_q[k-1] >= (RW'(dv_q[k-1]) << (QBITS - k))) begin
					rem_q[k] <= rem_q[k-1] - (RW'(dv_q[k-1]) << (QBITS - k));
					qt_q[k]  <= {qt_q[k-1][QBITS-2:0], 1'b1};
				end else begin
					rem_q[k] <= rem_q[k-1];
					qt_q[k]  <= {qt_q[k-1][QBITS-2:0], 1'b0};
				end
				dv_q[k]  <= dv_q[k-1];
				neg_q[k] <= neg_q[k-1];
				emp_q[k] <= emp_q[k-1];
				dz_q[k]  <= dz_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	always_comb begin
		qm      = qt_q[QBITS];
		qneg    = ~qm + {{(QBITS-1){1'b0}}, 1'b1};
		pos_sat = ovf_q[QBITS] | qm[32] | qm[31];
		neg_sat = ovf_q[QBITS] | qm[32] | (qm[31] & (|qm[30:0]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (emp_q[QBITS]) begin
				out_q.correction <= '0;
				out_q.status     <= ST_EMPTY;
			end else if (dz_q[QBITS]) begin
				out_q.correction <= '0;
				out_q.status     <= ST_DZERO;
			end else if (neg_q[QBITS]) begin
				out_q.correction <= neg_sat ? CORR_MIN : $signed(qneg[31:0]);
				out_q.status     <= neg_sat ? ST_SAT : ST_OK;
			end else begin
				out_q.correction <= pos_sat ? CORR_MAX : $signed(qm[31:0]);
				out_q.status     <= pos_sat ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

@@ sv/efuse_calibration_ratio_core.sv @@
// efuse_calibration_ratio_core: a front stage, the queue, three back stages,
// 33 restoring divide stages and an output register. Throughput one item per
// cycle while no stall holds it; the divider is fully pipelined, one quotient bit per stage.
// Reset clears all valids and the queue and loads the register defaults.
// Depends on ecr_pkg, ecr_front, ecr_queue, ecr_back.
`timescale 1ns / 1ps
module efuse_calibration_ratio_core import ecr_pkg::*; #(
	parameter int WORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int GW = (WORD_BITS + 12 > 16) ? WORD_BITS + 12 : 16;
	localparam int QW = 2 * GW + 1;

	logic [15:0] field_mask_q, ratio_scale_q;
	logic [9:0]  gain_weight_q;
	logic          push, full, pop, not_empty;
	logic [QW-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_mask_q  <= RST_FIELD_MASK;
			gain_weight_q <= RST_GAIN_WEIGHT;
			ratio_scale_q <= RST_RATIO_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_FIELD_MASK:  field_mask_q  <= cfg_data;
				REG_GAIN_WEIGHT: gain_weight_q <= cfg_data[9:0];
				REG_RATIO_SCALE: ratio_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ecr_front #(.FW(WORD_BITS), .GW(GW)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.field_mask(field_mask_q), .gain_weight(gain_weight_q),
		.q_full(full), .push, .push_data
	);

	ecr_queue #(.DW(QW)) u_queue (
		.clk, .arst_n, .push, .push_data, .full, .pop, .not_empty, .pop_data
	);

	ecr_back #(.GW(GW)) u_back (
		.clk, .arst_n, .q_not_empty(not_empty), .q_data(pop_data), .pop,
		.ratio_scale(ratio_scale_q), .out_valid, .out_stall, .out_data
	);

	// a saturated result sits on one of the two bounds
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_SAT |->
		out_data.correction == CORR_MAX || out_data.correction == CORR_MIN)
		else $error("saturated result off bound");

	// empty mask and zero divisor give a zero correction
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_EMPTY || out_data.status == ST_DZERO) |->
		out_data.correction == 32'sd0)
		else $error("error result with nonzero correction");

	// queue never overflows or underflows
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !not_empty))
		else $error("queue misuse");
endmodule
